FILE: rtl/core/calendar_date_day_arithmetic_unit_macros.svh
// ----------------------------------------------------------------------------
// Calendar date day arithmetic assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_DAY_ARITHMETIC_UNIT_MACROS_SVH
`define CALENDAR_DATE_DAY_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define CDDA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication
`define CDDA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

// condition never seen
`define CDDA_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

FILE: rtl/core/cdda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date day arithmetic package
// Types, constants and calendar tables shared by the block's modules.
// ----------------------------------------------------------------------------
package cdda_pkg;

   localparam int CMD_W    = 2;
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int OFFSET_W = 17;
   localparam int DIFF_W   = 22;
   localparam int SERIAL_W = 23;
   localparam int BYEAR_W  = 15;
   localparam int DOY_W    = 9;
   localparam int Q100_W   = 8;
   localparam int REM_W    = 7;
   localparam int EST_W    = 12;
   localparam int EST_SHIFT = 20;
   localparam int RECIP_SHIFT = 19;

   // years are biased by one Gregorian cycle so that all day numbers stay positive
   localparam logic [BYEAR_W-1:0]  YEAR_BIAS  = 15'd400;
   localparam logic [SERIAL_W-1:0] SERIAL_LO  = 23'd146464;
   localparam logic [SERIAL_W-1:0] SERIAL_HI  = 23'd3798522;
   localparam logic [EST_W-1:0]    EST_MULT   = 12'd2870;
   localparam logic [27:0]         RECIP_100  = 28'd5243;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD  = 2'd0,
      CMD_SUB  = 2'd1,
      CMD_DIFF = 2'd2,
      CMD_NOP  = 2'd3
   } cdda_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FWD_START,
      ST_FWD_WAIT,
      ST_FWD_SUM,
      ST_OFFSET,
      ST_EST,
      ST_INV_START,
      ST_INV_WAIT,
      ST_INV_CUR,
      ST_NEXT_START,
      ST_NEXT_WAIT,
      ST_NEXT_CHECK,
      ST_MONTH,
      ST_DIFF,
      ST_FINISH
   } cdda_state_type;

   typedef struct packed {
      logic capture;
      logic sel_other;
      logic fwd_start;
      logic fwd_sum;
      logic offset;
      logic diff;
      logic est;
      logic inv_start;
      logic inv_cur;
      logic next_start;
      logic step;
      logic month_init;
      logic month_step;
      logic load_out;
   } cdda_cmd_type;

   typedef struct packed {
      cdda_op_type op;
      logic        yd_done;
      logic        oor;
      logic        step_more;
      logic        month_more;
      logic        out_free;
   } cdda_sts_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] mon,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (mon)
         4'd2:                   len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] mon,
                                                 input logic leap);
      logic [DOY_W-1:0] base;
      case (mon)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + {8'b0, (leap && (mon > 4'd2))};
   endfunction

endpackage

FILE: rtl/core/cdda_year_days.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Year day counter
// Three-stage unit: days before the first of a biased year, and its leap flag.
// ----------------------------------------------------------------------------
module cdda_year_days (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cdda_pkg::BYEAR_W-1:0]   year,
   output logic                           done,
   output logic [cdda_pkg::SERIAL_W-1:0]  days,
   output logic                           leap
);
   import cdda_pkg::*;

   logic [2:0]            valid_ff;
   logic [BYEAR_W-1:0]    ya_ff;
   logic [SERIAL_W-1:0]   p365_ff;
   logic [Q100_W-1:0]     q_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [SERIAL_W-1:0]   days_ff;
   logic                  leap_ff;

   logic [27:0]           qprod;
   logic [BYEAR_W-1:0]    q100;
   logic [BYEAR_W-1:0]    rem_full;
   logic                  nz4;
   logic                  nz100;
   logic                  nz400;
   logic [BYEAR_W-1:0]    c4;
   logic [Q100_W-1:0]     c100;
   logic [5:0]            c400;
   logic [SERIAL_W-1:0]   days_in;

   assign qprod    = {13'b0, year} * RECIP_100;
   assign q100     = {7'b0, q_ff} * 15'd100;
   assign rem_full = ya_ff - q100;

   always_comb begin
      nz4     = (ya_ff[1:0] != 2'd0);
      nz100   = (rem_ff != 7'd0);
      nz400   = nz100 || (q_ff[1:0] != 2'd0);
      c4      = {2'b0, ya_ff[BYEAR_W-1:2]} + {14'b0, nz4};
      c100    = q_ff + {7'b0, nz100};
      c400    = q_ff[Q100_W-1:2] + {5'b0, nz400};
      days_in = p365_ff + {8'b0, c4} - {15'b0, c100} + {17'b0, c400};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 3'b000;
      end else begin
         valid_ff <= {valid_ff[1:0], start};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ya_ff   <= year;
         p365_ff <= {8'b0, year} * 23'd365;
         q_ff    <= qprod[RECIP_SHIFT+Q100_W-1:RECIP_SHIFT];
      end
      if (valid_ff[0]) begin
         rem_ff <= rem_full[REM_W-1:0];
      end
      if (valid_ff[1]) begin
         days_ff <= days_in;
         leap_ff <= !nz4 && (nz100 || (q_ff[1:0] == 2'd0));
      end
   end

   assign done = valid_ff[2];
   assign days = days_ff;
   assign leap = leap_ff;

endmodule

FILE: rtl/core/cdda_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date day arithmetic datapath
// Operand capture, day number conversion, year search, month walk, result.
// ----------------------------------------------------------------------------
module cdda_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cdda_pkg::cdda_cmd_type               cmd,
   output cdda_pkg::cdda_sts_type               sts,
   input  logic [cdda_pkg::CMD_W-1:0]           req_command,
   input  logic [cdda_pkg::YEAR_W-1:0]          req_year,
   input  logic [cdda_pkg::MONTH_W-1:0]         req_month,
   input  logic [cdda_pkg::DAY_W-1:0]           req_day,
   input  logic signed [cdda_pkg::OFFSET_W-1:0] req_day_offset,
   input  logic [cdda_pkg::YEAR_W-1:0]          req_other_year,
   input  logic [cdda_pkg::MONTH_W-1:0]         req_other_month,
   input  logic [cdda_pkg::DAY_W-1:0]           req_other_day,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cdda_pkg::YEAR_W-1:0]          rsp_result_year,
   output logic [cdda_pkg::MONTH_W-1:0]         rsp_result_month,
   output logic [cdda_pkg::DAY_W-1:0]           rsp_result_day,
   output logic [cdda_pkg::DIFF_W-1:0]          rsp_day_difference,
   output logic                                 rsp_status
);
   import cdda_pkg::*;

   cdda_op_type                op_ff;
   logic [YEAR_W-1:0]          yr_ff;
   logic [MONTH_W-1:0]         mo_ff;
   logic [DAY_W-1:0]           dy_ff;
   logic signed [OFFSET_W-1:0] off_ff;
   logic [YEAR_W-1:0]          oyr_ff;
   logic [MONTH_W-1:0]         omo_ff;
   logic [DAY_W-1:0]           ody_ff;

   logic [SERIAL_W-1:0]        s_ff;
   logic [SERIAL_W-1:0]        t_ff;
   logic [DIFF_W-1:0]          m_ff;
   logic [DIFF_W+EST_W-1:0]    est_ff;
   logic [BYEAR_W-1:0]         y_ff;
   logic [MONTH_W-1:0]         mon_ff;
   logic [DOY_W-1:0]           doy_ff;
   logic [SERIAL_W-1:0]        cur_days_ff;
   logic                       cur_leap_ff;
   logic                       oor_ff;
   logic [DIFF_W-1:0]          diff_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [YEAR_W-1:0]          rsp_year_ff;
   logic [MONTH_W-1:0]         rsp_month_ff;
   logic [DAY_W-1:0]           rsp_day_ff;
   logic [DIFF_W-1:0]          rsp_diff_ff;
   logic                       rsp_status_ff;
   logic [YEAR_W-1:0]          rsp_year_in;
   logic [MONTH_W-1:0]         rsp_month_in;
   logic [DAY_W-1:0]           rsp_day_in;
   logic [DIFF_W-1:0]          rsp_diff_in;
   logic                       rsp_status_in;

   logic [YEAR_W-1:0]          ysrc;
   logic [MONTH_W-1:0]         msrc;
   logic [DAY_W-1:0]           dsrc;
   logic [BYEAR_W-1:0]         norm_y;
   logic [MONTH_W-1:0]         norm_m;
   logic [BYEAR_W-1:0]         est_y;
   logic [BYEAR_W-1:0]         yd_year;
   logic                       yd_start;
   logic                       yd_done;
   logic [SERIAL_W-1:0]        yd_days;
   logic                       yd_leap;
   logic [SERIAL_W-1:0]        serial;
   logic [SERIAL_W:0]          shifted;
   logic [SERIAL_W:0]          off_ext;
   logic [SERIAL_W:0]          m_full;
   logic                       shift_oor;
   logic                       s_oor;
   logic                       t_oor;
   logic [SERIAL_W-1:0]        abs_diff;
   logic [SERIAL_W-1:0]        doy_full;
   logic [DAY_W-1:0]           cur_len;
   logic [BYEAR_W-1:0]         out_year;

   always_comb begin
      ysrc = cmd.sel_other ? oyr_ff : yr_ff;
      msrc = cmd.sel_other ? omo_ff : mo_ff;
      dsrc = cmd.sel_other ? ody_ff : dy_ff;
      case (msrc) inside
         4'd0: begin
            norm_y = {1'b0, ysrc} + YEAR_BIAS - 15'd1;
            norm_m = 4'd12;
         end
         [4'd13:4'd15]: begin
            norm_y = {1'b0, ysrc} + YEAR_BIAS + 15'd1;
            norm_m = msrc - 4'd12;
         end
         default: begin
            norm_y = {1'b0, ysrc} + YEAR_BIAS;
            norm_m = msrc;
         end
      endcase
   end

   assign est_y    = {1'b0, est_ff[EST_SHIFT+YEAR_W-1:EST_SHIFT]} - 15'd1;
   assign yd_start = cmd.fwd_start || cmd.inv_start || cmd.next_start;

   always_comb begin
      if (cmd.fwd_start) begin
         yd_year = norm_y;
      end else if (cmd.inv_start) begin
         yd_year = est_y;
      end else begin
         yd_year = y_ff + 15'd1;
      end
   end

   cdda_year_days u_year_days (
      .clock (clock),
      .reset (reset),
      .start (yd_start),
      .year  (yd_year),
      .done  (yd_done),
      .days  (yd_days),
      .leap  (yd_leap)
   );

   always_comb begin
      serial    = yd_days + {14'b0, cum_days(mon_ff, yd_leap)} + {18'b0, dsrc};
      off_ext   = {{(SERIAL_W+1-OFFSET_W){off_ff[OFFSET_W-1]}}, off_ff};
      shifted   = (op_ff == CMD_SUB) ? ({1'b0, s_ff} - off_ext) : ({1'b0, s_ff} + off_ext);
      shift_oor = shifted[SERIAL_W] || (shifted[SERIAL_W-1:0] < SERIAL_LO)
                  || (shifted[SERIAL_W-1:0] > SERIAL_HI);
      m_full    = shifted - 24'd1;
      s_oor     = (s_ff < SERIAL_LO) || (s_ff > SERIAL_HI);
      t_oor     = (t_ff < SERIAL_LO) || (t_ff > SERIAL_HI);
      abs_diff  = (s_ff > t_ff) ? (s_ff - t_ff) : (t_ff - s_ff);
      doy_full  = {1'b0, m_ff} - cur_days_ff;
      cur_len   = month_len(mon_ff, cur_leap_ff);
      out_year  = y_ff - YEAR_BIAS;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= cdda_op_type'(req_command);
         yr_ff  <= req_year;
         mo_ff  <= req_month;
         dy_ff  <= req_day;
         off_ff <= req_day_offset;
         oyr_ff <= req_other_year;
         omo_ff <= req_other_month;
         ody_ff <= req_other_day;
         oor_ff <= 1'b0;
      end
      if (cmd.fwd_start) begin
         y_ff   <= norm_y;
         mon_ff <= norm_m;
      end
      if (cmd.fwd_sum) begin
         if (cmd.sel_other) begin
            t_ff <= serial;
         end else begin
            s_ff <= serial;
         end
      end
      if (cmd.offset) begin
         oor_ff <= shift_oor;
         m_ff   <= m_full[DIFF_W-1:0];
      end
      if (cmd.diff) begin
         oor_ff  <= s_oor || t_oor;
         diff_ff <= abs_diff[DIFF_W-1:0];
      end
      if (cmd.est) begin
         est_ff <= {{EST_W{1'b0}}, m_ff} * {{DIFF_W{1'b0}}, EST_MULT};
      end
      if (cmd.inv_start) begin
         y_ff <= est_y;
      end
      if (cmd.inv_cur || cmd.step) begin
         cur_days_ff <= yd_days;
         cur_leap_ff <= yd_leap;
      end
      if (cmd.step) begin
         y_ff <= y_ff + 15'd1;
      end
      if (cmd.month_init) begin
         mon_ff <= 4'd1;
         doy_ff <= doy_full[DOY_W-1:0];
      end
      if (cmd.month_step) begin
         mon_ff <= mon_ff + 4'd1;
         doy_ff <= doy_ff - {4'b0, cur_len};
      end
   end

   always_comb begin
      rsp_year_in   = '0;
      rsp_month_in  = '0;
      rsp_day_in    = '0;
      rsp_diff_in   = '0;
      rsp_status_in = 1'b0;
      case (op_ff)
         CMD_ADD, CMD_SUB: begin
            rsp_status_in = oor_ff;
            if (!oor_ff) begin
               rsp_year_in  = out_year[YEAR_W-1:0];
               rsp_month_in = mon_ff;
               rsp_day_in   = doy_ff[DAY_W-1:0] + 5'd1;
            end
         end
         CMD_DIFF: begin
            rsp_status_in = oor_ff;
            if (!oor_ff) begin
               rsp_diff_in = diff_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_year_ff   <= rsp_year_in;
         rsp_month_ff  <= rsp_month_in;
         rsp_day_ff    <= rsp_day_in;
         rsp_diff_ff   <= rsp_diff_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_comb begin
      sts.op         = op_ff;
      sts.yd_done    = yd_done;
      sts.oor        = oor_ff;
      sts.step_more  = (yd_days <= {1'b0, m_ff});
      sts.month_more = (doy_ff >= {4'b0, cur_len});
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_year    = rsp_year_ff;
   assign rsp_result_month   = rsp_month_ff;
   assign rsp_result_day     = rsp_day_ff;
   assign rsp_day_difference = rsp_diff_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

FILE: rtl/core/cdda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date day arithmetic controller
// Sequences conversion, year search and month walk for one item at a time.
// ----------------------------------------------------------------------------
module cdda_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cdda_pkg::cdda_sts_type sts,
   output cdda_pkg::cdda_cmd_type cmd
);
   import cdda_pkg::*;

   cdda_state_type state_ff;
   cdda_state_type state_in;
   logic           second_ff;
   logic           second_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         second_ff <= second_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      second_in     = second_ff;
      cmd           = '0;
      cmd.sel_other = second_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               second_in   = 1'b0;
               state_in    = ST_FWD_START;
            end
         end
         ST_FWD_START: begin
            if (sts.op == CMD_NOP) begin
               state_in = ST_FINISH;
            end else begin
               cmd.fwd_start = 1'b1;
               state_in      = ST_FWD_WAIT;
            end
         end
         ST_FWD_WAIT: begin
            if (sts.yd_done) begin
               state_in = ST_FWD_SUM;
            end
         end
         ST_FWD_SUM: begin
            cmd.fwd_sum = 1'b1;
            if (sts.op == CMD_DIFF) begin
               if (second_ff) begin
                  state_in = ST_DIFF;
               end else begin
                  second_in = 1'b1;
                  state_in  = ST_FWD_START;
               end
            end else begin
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            cmd.offset = 1'b1;
            state_in   = ST_EST;
         end
         ST_EST: begin
            if (sts.oor) begin
               state_in = ST_FINISH;
            end else begin
               cmd.est  = 1'b1;
               state_in = ST_INV_START;
            end
         end
         ST_INV_START: begin
            cmd.inv_start = 1'b1;
            state_in      = ST_INV_WAIT;
         end
         ST_INV_WAIT: begin
            if (sts.yd_done) begin
               state_in = ST_INV_CUR;
            end
         end
         ST_INV_CUR: begin
            cmd.inv_cur = 1'b1;
            state_in    = ST_NEXT_START;
         end
         ST_NEXT_START: begin
            cmd.next_start = 1'b1;
            state_in       = ST_NEXT_WAIT;
         end
         ST_NEXT_WAIT: begin
            if (sts.yd_done) begin
               state_in = ST_NEXT_CHECK;
            end
         end
         ST_NEXT_CHECK: begin
            if (sts.step_more) begin
               cmd.step = 1'b1;
               state_in = ST_NEXT_START;
            end else begin
               cmd.month_init = 1'b1;
               state_in       = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (sts.month_more) begin
               cmd.month_step = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/calendar_date_day_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date day arithmetic unit
// Gregorian date plus or minus a day offset, and day count between two dates.
// ----------------------------------------------------------------------------
// Channel  Dir  Transfer               Payload
// req      in   req_valid, req_stall   command, first date, day offset, second date
// rsp      out  rsp_valid, rsp_stall   result date, day difference, status
//
// One item at a time: requests are taken only in idle. Difference converts both
// dates; add and subtract convert, shift, search years and walk months, unless
// the result leaves years 1..9999; command 3 only loads a result. Each year probe
// runs the three-stage year day unit; the month walk retires one month per cycle.
// Reset clears the controller and the result valid; no clearing pass.
// A result held by rsp_stall delays the next result load, not the next request.
// ----------------------------------------------------------------------------
module calendar_date_day_arithmetic_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [cdda_pkg::CMD_W-1:0]           req_command,
   input  logic [cdda_pkg::YEAR_W-1:0]          req_year,
   input  logic [cdda_pkg::MONTH_W-1:0]         req_month,
   input  logic [cdda_pkg::DAY_W-1:0]           req_day,
   input  logic signed [cdda_pkg::OFFSET_W-1:0] req_day_offset,
   input  logic [cdda_pkg::YEAR_W-1:0]          req_other_year,
   input  logic [cdda_pkg::MONTH_W-1:0]         req_other_month,
   input  logic [cdda_pkg::DAY_W-1:0]           req_other_day,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [cdda_pkg::YEAR_W-1:0]          rsp_result_year,
   output logic [cdda_pkg::MONTH_W-1:0]         rsp_result_month,
   output logic [cdda_pkg::DAY_W-1:0]           rsp_result_day,
   output logic [cdda_pkg::DIFF_W-1:0]          rsp_day_difference,
   output logic                                 rsp_status
);
   import cdda_pkg::*;

   cdda_cmd_type cmd;
   cdda_sts_type sts;

   cdda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdda_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_command        (req_command),
      .req_year           (req_year),
      .req_month          (req_month),
      .req_day            (req_day),
      .req_day_offset     (req_day_offset),
      .req_other_year     (req_other_year),
      .req_other_month    (req_other_month),
      .req_other_day      (req_other_day),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_year    (rsp_result_year),
      .rsp_result_month   (rsp_result_month),
      .rsp_result_day     (rsp_result_day),
      .rsp_day_difference (rsp_day_difference),
      .rsp_status         (rsp_status)
   );

endmodule

FILE: rtl/core/cdda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date day arithmetic port checker
// Result consistency and output hold rules seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "calendar_date_day_arithmetic_unit_macros.svh"

module cdda_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [cdda_pkg::YEAR_W-1:0]          rsp_result_year,
   input logic [cdda_pkg::MONTH_W-1:0]         rsp_result_month,
   input logic [cdda_pkg::DAY_W-1:0]           rsp_result_day,
   input logic [cdda_pkg::DIFF_W-1:0]          rsp_day_difference,
   input logic                                 rsp_status
);
   import cdda_pkg::*;

   `CDDA_ASSERT_NEVER(a_status_zero_fields, clock, reset, rsp_valid && rsp_status && (rsp_result_year != 14'd0 || rsp_result_month != 4'd0 || rsp_result_day != 5'd0 || rsp_day_difference != 22'd0))
   `CDDA_ASSERT_IMPL(a_diff_no_date, clock, reset, rsp_valid && (rsp_day_difference != 22'd0), (rsp_result_year == 14'd0) && (rsp_result_month == 4'd0) && (rsp_result_day == 5'd0))
   `CDDA_ASSERT_IMPL(a_date_legal, clock, reset, rsp_valid && (rsp_result_year != 14'd0), (rsp_result_year <= 14'd9999) && (rsp_result_month >= 4'd1) && (rsp_result_month <= 4'd12) && (rsp_result_day >= 5'd1))
   `CDDA_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_year) && $stable(rsp_result_month) && $stable(rsp_result_day) && $stable(rsp_day_difference) && $stable(rsp_status))

endmodule

bind calendar_date_day_arithmetic_unit cdda_checker u_cdda_checker (.*);

FILE: sim/calendar_date_day_arithmetic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date day arithmetic checker
// Watches the request and response channels of the date arithmetic unit.
// Predicts the resulting date, day difference and status for every request
// transfer and compares each response transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module calendar_date_day_arithmetic_checker
   import cdda_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [CMD_W-1:0]            req_command,
   input  logic [YEAR_W-1:0]           req_year,
   input  logic [MONTH_W-1:0]          req_month,
   input  logic [DAY_W-1:0]            req_day,
   input  logic signed [OFFSET_W-1:0]  req_day_offset,
   input  logic [YEAR_W-1:0]           req_other_year,
   input  logic [MONTH_W-1:0]          req_other_month,
   input  logic [DAY_W-1:0]            req_other_day,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [YEAR_W-1:0]           rsp_result_year,
   input  logic [MONTH_W-1:0]          rsp_result_month,
   input  logic [DAY_W-1:0]            rsp_result_day,
   input  logic [DIFF_W-1:0]           rsp_day_difference,
   input  logic                        rsp_status,
   output int unsigned                 mismatch_count,
   output int unsigned                 outstanding
);

   localparam int MONTHS_PER_YEAR = 12;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [DIFF_W-1:0]  diff;
      logic               status;
   } date_outcome_t;

   date_outcome_t pending_outcomes[$];
   int unsigned   fail_total = 0;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   function automatic longint floor_quot(input longint a, input longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   // day count from 1970-01-01; month and day may be out of their ranges
   function automatic longint day_number(input longint yr, input longint mo, input longint dy);
      longint mi, y, m, era, yoe, doy, doe;
      mi = yr * MONTHS_PER_YEAR + (mo - 1);
      y  = floor_quot(mi, MONTHS_PER_YEAR);
      m  = mi - y * MONTHS_PER_YEAR + 1;
      if (m <= 2) y = y - 1;
      era = floor_quot(y, 400);
      yoe = y - era * 400;
      doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * 146097 + doe - 719468 + (dy - 1);
   endfunction

   function automatic date_outcome_t civil_date(input longint dn);
      date_outcome_t res;
      longint z, era, doe, yoe, y, doy, mp, d, m;
      res = '0;
      z   = dn + 719468;
      era = floor_quot(z, 146097);
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      y   = yoe + era * 400;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      d   = doy - (153 * mp + 2) / 5 + 1;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      if (m <= 2) y = y + 1;
      res.year  = y[YEAR_W-1:0];
      res.month = m[MONTH_W-1:0];
      res.day   = d[DAY_W-1:0];
      return res;
   endfunction

   function automatic date_outcome_t date_outcome(
      input cdda_op_type               op,
      input logic [YEAR_W-1:0]         yr,
      input logic [MONTH_W-1:0]        mo,
      input logic [DAY_W-1:0]          dy,
      input logic signed [OFFSET_W-1:0] off,
      input logic [YEAR_W-1:0]         oyr,
      input logic [MONTH_W-1:0]        omo,
      input logic [DAY_W-1:0]          ody
   );
      date_outcome_t res;
      longint first_dn, last_dn, dn, other_dn, shift, moved;
      res      = '0;
      first_dn = day_number(1, 1, 1);
      last_dn  = day_number(9999, 12, 31);
      dn       = day_number(longint'(yr), longint'(mo), longint'(dy));
      shift    = longint'(off);
      case (op)
         CMD_ADD, CMD_SUB: begin
            moved = (op == CMD_ADD) ? dn + shift : dn - shift;
            if (moved < first_dn || moved > last_dn) res.status = 1'b1;
            else res = civil_date(moved);
         end
         CMD_DIFF: begin
            other_dn = day_number(longint'(oyr), longint'(omo), longint'(ody));
            if (dn < first_dn || dn > last_dn || other_dn < first_dn || other_dn > last_dn)
               res.status = 1'b1;
            else
               res.diff = (dn > other_dn) ? DIFF_W'(dn - other_dn) : DIFF_W'(other_dn - dn);
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      date_outcome_t want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $error("response transfer with no request outstanding");
               fail_total++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_result_year !== want.year) begin
                  $error("result_year: expected %0d, actual %0d", want.year, rsp_result_year);
                  fail_total++;
               end
               if (rsp_result_month !== want.month) begin
                  $error("result_month: expected %0d, actual %0d", want.month,
                         rsp_result_month);
                  fail_total++;
               end
               if (rsp_result_day !== want.day) begin
                  $error("result_day: expected %0d, actual %0d", want.day, rsp_result_day);
                  fail_total++;
               end
               if (rsp_day_difference !== want.diff) begin
                  $error("day_difference: expected %0d, actual %0d", want.diff,
                         rsp_day_difference);
                  fail_total++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_outcomes.push_back(date_outcome(cdda_op_type'(req_command), req_year,
               req_month, req_day, req_day_offset, req_other_year, req_other_month,
               req_other_day));
      end
      mismatch_count <= fail_total;
      outstanding    <= pending_outcomes.size();
   end

endmodule

FILE: sim/calendar_date_day_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date day arithmetic unit testbench
// Drives directed and random date requests through the unit with varying
// sender gaps and receiver stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module calendar_date_day_arithmetic_unit_tb;
   import cdda_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int TAIL_CYCLES  = 100;
   localparam int PHASE_ITEMS  = 62;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   cdda_op_type                req_command     = CMD_ADD;
   logic [YEAR_W-1:0]          req_year        = '0;
   logic [MONTH_W-1:0]         req_month       = '0;
   logic [DAY_W-1:0]           req_day         = '0;
   logic signed [OFFSET_W-1:0] req_day_offset  = '0;
   logic [YEAR_W-1:0]          req_other_year  = '0;
   logic [MONTH_W-1:0]         req_other_month = '0;
   logic [DAY_W-1:0]           req_other_day   = '0;
   logic                       rsp_stall       = 1'b0;

   logic                       req_stall;
   logic                       rsp_valid;
   logic [YEAR_W-1:0]          rsp_result_year;
   logic [MONTH_W-1:0]         rsp_result_month;
   logic [DAY_W-1:0]           rsp_result_day;
   logic [DIFF_W-1:0]          rsp_day_difference;
   logic                       rsp_status;

   int unsigned mismatch_count;
   int unsigned outstanding;
   int unsigned cycle_count = 0;
   int          idle_pct    = 0;
   int          stall_pct   = 0;

   always #5 clock = ~clock;

   calendar_date_day_arithmetic_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_year           (req_year),
      .req_month          (req_month),
      .req_day            (req_day),
      .req_day_offset     (req_day_offset),
      .req_other_year     (req_other_year),
      .req_other_month    (req_other_month),
      .req_other_day      (req_other_day),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_year    (rsp_result_year),
      .rsp_result_month   (rsp_result_month),
      .rsp_result_day     (rsp_result_day),
      .rsp_day_difference (rsp_day_difference),
      .rsp_status         (rsp_status)
   );

   calendar_date_day_arithmetic_checker result_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_year           (req_year),
      .req_month          (req_month),
      .req_day            (req_day),
      .req_day_offset     (req_day_offset),
      .req_other_year     (req_other_year),
      .req_other_month    (req_other_month),
      .req_other_day      (req_other_day),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_year    (rsp_result_year),
      .rsp_result_month   (rsp_result_month),
      .rsp_result_day     (rsp_result_day),
      .rsp_day_difference (rsp_day_difference),
      .rsp_status         (rsp_status),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("calendar_date_day_arithmetic_unit_tb: FAIL");
         $finish;
      end
   end

   task automatic send_date_request(
      input cdda_op_type                cmd,
      input logic [YEAR_W-1:0]          yr,
      input logic [MONTH_W-1:0]         mo,
      input logic [DAY_W-1:0]           dy,
      input logic signed [OFFSET_W-1:0] off,
      input logic [YEAR_W-1:0]          oyr,
      input logic [MONTH_W-1:0]         omo,
      input logic [DAY_W-1:0]           ody
   );
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_year        <= yr;
      req_month       <= mo;
      req_day         <= dy;
      req_day_offset  <= off;
      req_other_year  <= oyr;
      req_other_month <= omo;
      req_other_day   <= ody;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pick_date(output logic [YEAR_W-1:0] yr, output logic [MONTH_W-1:0] mo,
                            output logic [DAY_W-1:0] dy);
      int r;
      r = $urandom_range(9);
      if (r < 7) begin
         yr = YEAR_W'($urandom_range(1, 9999));
         mo = MONTH_W'($urandom_range(1, 12));
         dy = DAY_W'($urandom_range(1, $urandom_range(1) ? 28 : 31));
      end else if (r < 9) begin
         yr = YEAR_W'($urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999));
         mo = MONTH_W'($urandom_range(1, 12));
         dy = DAY_W'($urandom_range(1, 31));
      end else begin
         yr = YEAR_W'($urandom_range(16383));
         mo = MONTH_W'($urandom_range(15));
         dy = DAY_W'($urandom_range(31));
      end
   endtask

   task automatic send_random_request();
      cdda_op_type                cmd;
      logic [YEAR_W-1:0]          yr, oyr;
      logic [MONTH_W-1:0]         mo, omo;
      logic [DAY_W-1:0]           dy, ody;
      logic signed [OFFSET_W-1:0] off;
      if ($urandom_range(99) < 5) cmd = cdda_op_type'($urandom_range(3));
      else cmd = cdda_op_type'($urandom_range(2));
      pick_date(yr, mo, dy);
      pick_date(oyr, omo, ody);
      if (cmd == CMD_DIFF && $urandom_range(1)) begin
         oyr = yr;
         omo = MONTH_W'($urandom_range(1, 12));
      end
      case ($urandom_range(3))
         0: off = OFFSET_W'($urandom_range(131071));
         1, 2: off = OFFSET_W'($urandom_range(400));
         default: off = OFFSET_W'($urandom_range(65535));
      endcase
      if ($urandom_range(1)) off = -off;
      send_date_request(cmd, yr, mo, dy, off, oyr, omo, ody);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_date_request(CMD_ADD, 2000, 2, 28, 1, 0, 0, 0);
      send_date_request(CMD_ADD, 1900, 2, 28, 1, 0, 0, 0);
      send_date_request(CMD_ADD, 2024, 12, 31, 1, 0, 0, 0);
      send_date_request(CMD_SUB, 2024, 3, 1, 1, 0, 0, 0);
      send_date_request(CMD_SUB, 2024, 1, 1, -65535, 0, 0, 0);
      send_date_request(CMD_ADD, 9999, 1, 1, 65535, 0, 0, 0);
      send_date_request(CMD_ADD, 1, 1, 1, -1, 0, 0, 0);
      send_date_request(CMD_SUB, 1, 1, 1, 0, 0, 0, 0);
      send_date_request(CMD_ADD, 9999, 12, 31, 0, 0, 0, 0);
      send_date_request(CMD_ADD, 5000, 6, 15, 17'sh10000, 0, 0, 0);
      send_date_request(CMD_SUB, 5000, 6, 15, 17'sh10000, 0, 0, 0);
      send_date_request(CMD_DIFF, 1, 1, 1, 0, 9999, 12, 31);
      send_date_request(CMD_DIFF, 9999, 12, 31, 0, 1, 1, 1);
      send_date_request(CMD_DIFF, 2024, 7, 4, 0, 2024, 7, 4);
      send_date_request(CMD_DIFF, 0, 6, 1, 0, 2000, 1, 1);
      send_date_request(CMD_DIFF, 2000, 1, 1, 0, 16383, 15, 31);
      send_date_request(CMD_DIFF, 0, 0, 0, 0, 0, 0, 0);
      send_date_request(CMD_ADD, 2000, 0, 15, 0, 0, 0, 0);
      send_date_request(CMD_ADD, 2023, 2, 31, 0, 0, 0, 0);
      send_date_request(CMD_ADD, 2023, 15, 0, 0, 0, 0, 0);
      send_date_request(CMD_ADD, 0, 12, 31, 1, 0, 0, 0);
      send_date_request(CMD_SUB, 10000, 0, 0, 0, 0, 0, 0);
      send_date_request(CMD_ADD, 16383, 15, 31, 65535, 0, 0, 0);
      send_date_request(CMD_NOP, 2024, 5, 5, 100, 16383, 15, 31);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 48; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 8; stall_pct = 8; end
         endcase
         repeat (PHASE_ITEMS) send_random_request();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("calendar_date_day_arithmetic_unit_tb: PASS");
      else
         $display("calendar_date_day_arithmetic_unit_tb: FAIL");
      $finish;
   end

endmodule
